// ===== hdl/pidaw_pkg.sv =====
// Package with shared constants and types for the PID regulator with anti-windup.
package pidaw_pkg;

	localparam int QW = 32;
	localparam int PW = 31;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PER = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MIN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ACCUM_LIM  = 3'd6;

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic       command;
		logic [QW-1:0] error_in;
	} pidaw_in_t;

	typedef struct packed {
		logic [QW-1:0] drive;
		logic          saturated;
	} pidaw_out_t;

	// Saturate a 66-bit signed value to 32 bits.
	function automatic logic signed [QW-1:0] sat66(input logic signed [65:0] v);
		logic signed [QW-1:0] r;
		if (v > 66'sh0_7FFF_FFFF)
			r = Q_MAX;
		else if (v < -66'sh0_8000_0000)
			r = Q_MIN;
		else
			r = v[QW-1:0];
		return r;
	endfunction

endpackage

// ===== hdl/pidaw_if.sv =====
// Valid/ready channel interface carrying one payload.
interface pidaw_if #(parameter type payload_t = logic) (input logic clk);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/pidaw_mul.sv =====
// Bit-serial signed multiplier: 32x32 signed, one multiplier bit per cycle.
module pidaw_mul import pidaw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [QW-1:0] a,
	input  logic signed [QW-1:0] b,
	output logic                 done,
	output logic signed [63:0]   prod
);

	logic signed [QW:0]   acc_q;
	logic [QW-1:0]        mpl_q;
	logic signed [QW-1:0] mcd_q;
	logic [5:0]           cnt_q;
	logic                 busy_q;
	logic signed [QW:0]   addend;
	logic signed [QW+1:0] nxt;

	// The top multiplier bit carries negative weight.
	always_comb begin
		addend = mpl_q[0] ? {mcd_q[QW-1], mcd_q} : '0;
		if (cnt_q == 6'(QW - 1))
			nxt = {acc_q[QW], acc_q} - {addend[QW], addend};
		else
			nxt = {acc_q[QW], acc_q} + {addend[QW], addend};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(QW - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mpl_q <= b;
			mcd_q <= a;
		end else if (busy_q) begin
			acc_q <= nxt[QW+1:1];
			mpl_q <= {nxt[0], mpl_q[QW-1:1]};
		end
	end

	assign prod = {acc_q[QW-1:0], mpl_q};

endmodule

// ===== hdl/pidaw_div.sv =====
// Restoring divider: unsigned 48-bit dividend by 31-bit divisor, one bit per cycle.
module pidaw_div import pidaw_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [47:0]   dividend,
	input  logic [PW-1:0] divisor,
	output logic          done,
	output logic [47:0]   quot
);

	logic [PW:0]   rem_q;
	logic [47:0]   quo_q;
	logic [PW-1:0] dvs_q;
	logic [5:0]    cnt_q;
	logic          busy_q;
	logic [PW+1:0] trial;
	logic [PW:0]   shifted;

	always_comb begin
		shifted = {rem_q[PW-1:0], quo_q[47]};
		trial   = {1'b0, shifted} - {2'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd47) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[PW+1]) begin
				rem_q <= trial[PW:0];
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end

	assign quot = quo_q;

endmodule

// ===== hdl/pid_controller_antiwindup.sv =====
// Top level of the PID regulator: sequencer, state and configuration registers.
//
//  channel | dir | payload
//  in_ch   | in  | command, error_in
//  out_ch  | out | drive, saturated
//  cfg     | in  | cfg_we, cfg_index, cfg_data
//
// An update makes four passes through the shared bit-serial multiplier and one through
// the serial divider: accept, proportional, two integral passes, accumulator, derivative,
// divider, sum and hand-off, in that order. A clear goes from the accept straight to the
// hand-off. One item is worked on at a time; a finished result waits in the sequencer
// while the output register still holds an untaken beat.
// Reset clears accumulator, last error and configuration to their reset values.
module pid_controller_antiwindup import pidaw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [QW-1:0]        cfg_data,
	pidaw_if.sink                in_ch,
	pidaw_if.source              out_ch
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_PMUL  = 4'd1;
	localparam logic [3:0] ST_IMUL1 = 4'd2;
	localparam logic [3:0] ST_IMUL2 = 4'd3;
	localparam logic [3:0] ST_ACC   = 4'd4;
	localparam logic [3:0] ST_DMUL  = 4'd5;
	localparam logic [3:0] ST_DIV   = 4'd6;
	localparam logic [3:0] ST_SUM   = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;

	logic signed [QW-1:0] prop_gain_q, integ_gain_q, deriv_gain_q, drive_min_q, drive_max_q;
	logic [PW-1:0]        sample_period_q, accum_limit_q;
	logic signed [QW-1:0] acc_q, last_err_q, err_q, p_q, inc_q, d_q;
	logic [3:0]           state_q;
	logic                 wait_q;
	logic                 out_valid_q;
	pidaw_out_t           out_q;
	pidaw_out_t           res_q;
	logic                 out_load;

	logic                 mul_start, mul_done;
	logic signed [QW-1:0] mul_a, mul_b;
	logic signed [63:0]   mul_prod;
	logic                 div_start, div_done;
	logic [47:0]          div_num, div_quot;
	logic [PW-1:0]        dt;
	logic signed [QW-1:0] mul_q16;
	logic signed [QW-1:0] acc_add, acc_clamped, diff, d_sat, sum_sat, acc_back;
	logic signed [QW:0]   lim_s;
	logic                 d_neg;
	logic [QW-1:0]        d_mag;
	logic signed [QW+1:0] div_signed;

	assign dt = (sample_period_q == '0) ? PW'(1) : sample_period_q;

	pidaw_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(mul_prod)
	);

	pidaw_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_num),
		.divisor(dt), .done(div_done), .quot(div_quot)
	);

	// Arithmetic shift floors, matching the truncation toward minus infinity.
	assign mul_q16 = sat66({{18{mul_prod[63]}}, mul_prod[63:16]});

	always_comb begin
		mul_a = prop_gain_q;
		mul_b = err_q;
		case (state_q)
			ST_IMUL1: begin mul_a = integ_gain_q; mul_b = err_q; end
			ST_IMUL2: begin mul_a = inc_q; mul_b = QW'(dt); end
			ST_DMUL:  begin mul_a = deriv_gain_q; mul_b = diff; end
			default:  begin mul_a = prop_gain_q; mul_b = err_q; end
		endcase
	end

	always_comb begin
		lim_s       = {2'b0, accum_limit_q};
		acc_add     = sat66(66'(acc_q) + 66'(inc_q));
		if ($signed({acc_add[QW-1], acc_add}) > lim_s)
			acc_clamped = QW'(lim_s);
		else if ($signed({acc_add[QW-1], acc_add}) < -lim_s)
			acc_clamped = QW'(-lim_s);
		else
			acc_clamped = acc_add;
		diff        = sat66(66'(err_q) - 66'(last_err_q));
		d_neg       = d_q[QW-1];
		d_mag       = d_neg ? QW'(-{d_q[QW-1], d_q}) : d_q;
		div_num     = {d_mag, 16'h0000};
		div_signed  = d_neg ? -{2'b0, div_quot[QW-1:0]} : {2'b0, div_quot[QW-1:0]};
		// A negative quotient of exactly 2^31 still fits; anything larger saturates.
		d_sat       = (div_quot[47:QW] != '0 ||
			(div_quot[QW-1] && (!d_neg || div_quot[QW-2:0] != '0))) ?
			(d_neg ? Q_MIN : Q_MAX) : QW'(div_signed);
		sum_sat     = sat66(66'(p_q) + 66'(acc_q) + 66'(d_q));
		acc_back    = sat66(66'(acc_q) - 66'(inc_q));
	end

	assign mul_start = !wait_q && (state_q == ST_PMUL || state_q == ST_IMUL1 ||
		state_q == ST_IMUL2 || state_q == ST_DMUL);
	assign div_start = !wait_q && state_q == ST_DIV;

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ch.ready);

	assign in_ch.ready    = (state_q == ST_IDLE);
	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q     <= '0;
			integ_gain_q    <= '0;
			deriv_gain_q    <= '0;
			sample_period_q <= PW'(65536);
			drive_min_q     <= Q_MIN;
			drive_max_q     <= Q_MAX;
			accum_limit_q   <= {PW{1'b1}};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PROP_GAIN:  prop_gain_q     <= cfg_data;
				REG_INTEG_GAIN: integ_gain_q    <= cfg_data;
				REG_DERIV_GAIN: deriv_gain_q    <= cfg_data;
				REG_SAMPLE_PER: sample_period_q <= cfg_data[PW-1:0];
				REG_DRIVE_MIN:  drive_min_q     <= cfg_data;
				REG_DRIVE_MAX:  drive_max_q     <= cfg_data;
				REG_ACCUM_LIM:  accum_limit_q   <= cfg_data[PW-1:0];
				default: ;
			endcase
		end
	end

	// Output register: loaded from the sequencer when empty or being taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (out_load) begin
			out_q       <= res_q;
			out_valid_q <= 1'b1;
		end else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wait_q      <= 1'b0;
			acc_q       <= '0;
			last_err_q  <= '0;
			err_q       <= '0;
			p_q         <= '0;
			inc_q       <= '0;
			d_q         <= '0;
			res_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						if (in_ch.payload.command == CMD_CLEAR) begin
							acc_q      <= '0;
							last_err_q <= '0;
							res_q      <= '{drive: '0, saturated: 1'b0};
							state_q    <= ST_OUT;
						end else begin
							err_q   <= in_ch.payload.error_in;
							state_q <= ST_PMUL;
							wait_q  <= 1'b0;
						end
					end
				end
				ST_PMUL, ST_IMUL1, ST_IMUL2, ST_DMUL: begin
					if (!wait_q)
						wait_q <= 1'b1;
					else if (mul_done) begin
						wait_q <= 1'b0;
						case (state_q)
							ST_PMUL:  begin p_q <= mul_q16; state_q <= ST_IMUL1; end
							ST_IMUL1: begin inc_q <= mul_q16; state_q <= ST_IMUL2; end
							ST_IMUL2: begin inc_q <= mul_q16; state_q <= ST_ACC; end
							default:  begin d_q <= mul_q16; state_q <= ST_DIV; end
						endcase
					end
				end
				ST_ACC: begin
					acc_q   <= acc_clamped;
					state_q <= ST_DMUL;
				end
				ST_DIV: begin
					if (!wait_q)
						wait_q <= 1'b1;
					else if (div_done) begin
						wait_q  <= 1'b0;
						d_q     <= d_sat;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					state_q <= ST_OUT;
					// Upper bound is checked first, so with crossed limits a sum above drive_max gives drive_max.
					if (sum_sat > drive_max_q) begin
						res_q  <= '{drive: drive_max_q, saturated: 1'b1};
						acc_q  <= acc_back;
					end else if (sum_sat < drive_min_q) begin
						res_q  <= '{drive: drive_min_q, saturated: 1'b1};
						acc_q  <= acc_back;
					end else
						res_q  <= '{drive: sum_sat, saturated: 1'b0};
					last_err_q <= err_q;
				end
				ST_OUT: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ch.ready)
		else $error("input accepted while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.payload)))
		else $error("output beat dropped");
	a_acc_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC) |=>
		($signed({acc_q[QW-1], acc_q}) <= $signed({2'b0, accum_limit_q})))
		else $error("accumulator above limit");
`endif

endmodule

// ===== tb/pid_controller_antiwindup_test.sv =====
// Testbench for the PID regulator with integrator clamp: directed table, random traffic, checks.
module pid_controller_antiwindup_test import pidaw_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM = 850;
	localparam longint CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [QW-1:0] cfg_data = '0;

	pidaw_if #(.payload_t(pidaw_in_t)) in_ch (clk);
	pidaw_if #(.payload_t(pidaw_out_t)) out_ch (clk);

	pid_controller_antiwindup dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow of the configuration and the regulator state.
	logic signed [31:0] kp, ki, kd, dmin, dmax;
	logic [30:0] period, ilimit;
	longint integ, prev_err;

	pidaw_out_t drive_queue[$];
	int mismatches = 0;
	bit long_hold = 1'b0;
	longint cycles = 0;

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Q16.16 product with floor rounding, saturated.
	function automatic longint qprod(longint a, longint b);
		longint p;
		p = a * b;
		return clamp32(p >>> 16);
	endfunction

	function automatic pidaw_out_t regulate(pidaw_in_t item);
		pidaw_out_t r;
		longint e, dt, p, inc, lim, diff, d, total;
		r.drive = '0;
		r.saturated = 1'b0;
		if (item.command == CMD_CLEAR) begin
			integ = 0;
			prev_err = 0;
			return r;
		end
		e = longint'($signed(item.error_in));
		dt = (period == 0) ? 1 : longint'(period);
		lim = longint'(ilimit);
		p = qprod(kp, e);
		inc = qprod(qprod(ki, e), dt);
		integ = clamp32(integ + inc);
		if (integ > lim) integ = lim;
		else if (integ < -lim) integ = -lim;
		diff = clamp32(e - prev_err);
		d = qprod(kd, diff);
		d = clamp32((d * 65536) / dt);
		total = clamp32(p + integ + d);
		if (total > longint'(dmax)) begin
			total = dmax;
			integ = clamp32(integ - inc);
			r.saturated = 1'b1;
		end else if (total < longint'(dmin)) begin
			total = dmin;
			integ = clamp32(integ - inc);
			r.saturated = 1'b1;
		end
		prev_err = e;
		r.drive = total[31:0];
		return r;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_PROP_GAIN: kp = val;
			REG_INTEG_GAIN: ki = val;
			REG_DERIV_GAIN: kd = val;
			REG_SAMPLE_PER: period = val[30:0];
			REG_DRIVE_MIN: dmin = val;
			REG_DRIVE_MAX: dmax = val;
			REG_ACCUM_LIM: ilimit = val[30:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [31:0] p, i, d, t, lo, hi, lim);
		write_reg(REG_PROP_GAIN, p);
		write_reg(REG_INTEG_GAIN, i);
		write_reg(REG_DERIV_GAIN, d);
		write_reg(REG_SAMPLE_PER, t);
		write_reg(REG_DRIVE_MIN, lo);
		write_reg(REG_DRIVE_MAX, hi);
		write_reg(REG_ACCUM_LIM, lim);
		cfg_we <= 1'b0;
	endtask

	// Drops valid for a number of cycles; a count of zero leaves the line untouched.
	task automatic idle_input(input int n);
		if (n != 0) begin
			in_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Sends one beat, with an optional random gap, and records its expectation.
	// Valid stays high after the beat so that the next one can follow at once.
	task automatic send_item(input logic cmd, input logic [31:0] e, input bit gap);
		pidaw_in_t item;
		item.command = cmd;
		item.error_in = e;
		if (gap)
			idle_input($urandom_range(0, 6));
		in_ch.valid <= 1'b1;
		in_ch.payload <= item;
		do @(posedge clk); while (!in_ch.ready);
		drive_queue.push_back(regulate(item));
	endtask

	task automatic drain;
		in_ch.valid <= 1'b0;
		while (drive_queue.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_err(int mode);
		case (mode)
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
			default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		endcase
	endfunction

	typedef struct {
		logic cmd;
		logic [31:0] err;
		bit known;
		logic [31:0] drive;
		logic sat;
	} row_t;

	// Result checker: compares each beat with the oldest expectation.
	always @(posedge clk) begin
		pidaw_out_t want;
		if (out_ch.valid && out_ch.ready) begin
			if (drive_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat drive=%h sat=%b",
						out_ch.payload.drive, out_ch.payload.saturated);
			end else begin
				want = drive_queue.pop_front();
				if (want.drive !== out_ch.payload.drive ||
						want.saturated !== out_ch.payload.saturated) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected drive=%h sat=%b, got drive=%h sat=%b",
							want.drive, want.saturated, out_ch.payload.drive,
							out_ch.payload.saturated);
				end
			end
		end
	end

	// Receiver stall pattern, with one long hold-off while the sender keeps going.
	always @(posedge clk) begin
		if (!arst_n)
			out_ch.ready <= 1'b0;
		else if (long_hold)
			out_ch.ready <= 1'b0;
		else
			out_ch.ready <= ($urandom_range(0, 3) != 0) || (cycles[9:8] == 2'b01);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		pidaw_out_t want;
		int burst;
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		kp = 0; ki = 0; kd = 0; period = 31'd65536;
		dmin = 32'h8000_0000; dmax = 32'h7FFF_FFFF; ilimit = 31'h7FFF_FFFF;
		integ = 0; prev_err = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset all gains are zero, so every update gives zero.
		rows.push_back('{CMD_UPDATE, 32'h7FFF_FFFF, 1, 32'h0, 1'b0});
		rows.push_back('{CMD_UPDATE, 32'h8000_0000, 1, 32'h0, 1'b0});
		rows.push_back('{CMD_CLEAR, 32'h1234_5678, 1, 32'h0, 1'b0});
		foreach (rows[k]) begin
			send_item(rows[k].cmd, rows[k].err, 1'b0);
			if (rows[k].known) begin
				want.drive = rows[k].drive;
				want.saturated = rows[k].sat;
				drive_queue[drive_queue.size() - 1] = want;
			end
		end
		drain();

		// Extreme gains with a zero sample period and crossed output limits.
		write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
			32'h0001_0000, 32'hFFFF_0000, 32'h0);
		rows.delete();
		rows.push_back('{CMD_UPDATE, 32'h7FFF_FFFF, 0, 0, 0});
		rows.push_back('{CMD_UPDATE, 32'h8000_0000, 0, 0, 0});
		rows.push_back('{CMD_UPDATE, 32'h0, 0, 0, 0});
		rows.push_back('{CMD_CLEAR, 32'h0, 1, 32'h0, 1'b0});
		rows.push_back('{CMD_UPDATE, 32'hFFFF_FFFF, 0, 0, 0});
		foreach (rows[k])
			send_item(rows[k].cmd, rows[k].err, 1'b1);
		drain();

		// Narrow limits so the take-back path and the integrator clamp both fire.
		write_all(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h7FFF_FFFF,
			32'hFFF0_0000, 32'h0010_0000, 31'h0008_0000);
		rows.delete();
		rows.push_back('{CMD_UPDATE, 32'h0020_0000, 0, 0, 0});
		rows.push_back('{CMD_UPDATE, 32'hFFE0_0000, 0, 0, 0});
		rows.push_back('{CMD_UPDATE, 32'h0000_0001, 0, 0, 0});
		rows.push_back('{CMD_UPDATE, 32'h0004_0000, 0, 0, 0});
		rows.push_back('{CMD_CLEAR, 32'hFFFF_FFFF, 1, 32'h0, 1'b0});
		foreach (rows[k])
			send_item(rows[k].cmd, rows[k].err, 1'b1);

		// Long receiver hold-off: the sender keeps offering until the input stalls.
		long_hold = 1'b1;
		fork
			begin
				repeat (1500) @(posedge clk);
				long_hold = 1'b0;
			end
			repeat (6) send_item(CMD_UPDATE, rand_err(1), 1'b0);
		join
		drain();

		// Random phases, each with its own configuration.
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 5)
				write_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
					32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
			else
				write_all($urandom_range(0, 1) ? $urandom() : $urandom_range(0, 1 << 18),
					$urandom_range(0, 1) ? $urandom() : $urandom_range(0, 1 << 17),
					$urandom_range(0, 1) ? $urandom() : $urandom_range(0, 1 << 17),
					$urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 1 << 17),
					$urandom_range(0, 1) ? $urandom() : 32'hFF00_0000,
					$urandom_range(0, 1) ? $urandom() : 32'h0100_0000,
					$urandom());
			for (int n = 0; n < N_RANDOM / 6; ) begin
				burst = $urandom_range(1, 12);
				for (int b = 0; b < burst; b++, n++)
					send_item($urandom_range(0, 15) == 0 ? CMD_CLEAR : CMD_UPDATE,
						rand_err($urandom_range(0, 2)), 1'b0);
				idle_input($urandom_range(0, 400));
			end
			drain();
		end

		if (mismatches == 0 && drive_queue.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

// ===== filelist.f =====
hdl/pidaw_pkg.sv
hdl/pidaw_if.sv
hdl/pidaw_mul.sv
hdl/pidaw_div.sv
hdl/pid_controller_antiwindup.sv
tb/pid_controller_antiwindup_test.sv
